// ===== rtl/core/tshof_pkg.sv =====
// Package for the two-sigma height outlier filter.
// Holds payload structs, widths and sizing constants; no dependencies.
`default_nettype none
package tshof_pkg;

    localparam int MAX_POINTS = 64;           // points that close a set without a last mark
    localparam int HEIGHT_W   = 24;           // height, signed, 8 fraction bits
    localparam int IDX_W      = 6;            // load-order index
    localparam int CNT_W      = 7;            // point count, holds MAX_POINTS itself
    localparam int SUM_W      = 31;           // signed height sum
    localparam int DIFF_W     = HEIGHT_W + 1; // signed deviation from the mean
    localparam int SQ_W       = 2 * HEIGHT_W; // square of |deviation|
    localparam int PROD_W     = SQ_W + CNT_W; // count * square
    localparam int ACC_W      = SQ_W + IDX_W + 1;
    localparam int LIM_W      = ACC_W + 2;    // 4 * sum of squares

    typedef struct packed {
        logic signed [HEIGHT_W-1:0] height;
        logic                       last_point;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]           point_index;
        logic signed [HEIGHT_W-1:0] kept_height;
        logic                       last_kept;
    } t_out_item;

endpackage
`default_nettype wire

// ===== rtl/core/two_sigma_height_outlier_filter_top.sv =====
// Top level of the two-sigma height outlier filter.
// Depends on tshof_pkg and the generic RAM tshof_ram.
`default_nettype none
// Points are loaded one per transfer (start high while busy is low) into a
// 64-entry height RAM, while a running sum and count are kept. The transfer
// that carries last_point, or the 64th point, closes the set and raises busy.
// The block then works through the set: a restoring divider forms the mean
// (31 quotient steps, then the sign), a variance pass reads every point once
// from the RAM (one read per cycle), and an emit pass reads every point
// again. Busy stays high through the divider and both passes; during loading
// one point is taken per cycle. Kept points come out in load order, each on
// o_result for a single cycle marked by o_result_valid, and the receiver
// cannot stall them. Each kept point is held back until the next kept point
// (or the end of the pass) is seen, so that the final one can carry
// last_kept; that final transfer is strobed in the first cycle after busy
// falls. Every closed set gives at least one result.
module two_sigma_height_outlier_filter_top (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    input  wire tshof_pkg::t_in_item  i_item,
    output logic                      busy,
    output logic                      o_result_valid,
    output tshof_pkg::t_out_item      o_result
);
    import tshof_pkg::*;

    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_VAR  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    localparam logic [4:0] DIV_STEPS = 5'(SUM_W);

    logic [1:0] r_state;

    // Loading state
    logic [CNT_W-1:0]        r_cnt;
    logic signed [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0]        r_n;
    logic [CNT_W-1:0]        n_cnt;
    logic signed [SUM_W-1:0] n_sum;
    logic                    accept;
    logic                    closes;

    // Divider
    logic [SUM_W-1:0]        r_dq;
    logic [CNT_W-1:0]        r_rem;
    logic [4:0]              r_dcnt;
    logic                    r_neg;
    logic [CNT_W:0]          div_trial;
    logic                    div_bit;
    logic signed [HEIGHT_W-1:0] r_mean;

    // Read passes
    logic [CNT_W-1:0]        r_ptr;
    logic                    issue;
    logic [HEIGHT_W-1:0]     rdata;
    logic                    r_v0, r_v1, r_v2, r_v3;
    logic [IDX_W-1:0]        r_i0, r_i1, r_i2, r_i3;
    logic [HEIGHT_W-1:0]     r_h1, r_h2, r_h3;
    logic [HEIGHT_W-1:0]     r_absd;
    logic [SQ_W-1:0]         r_sq;
    logic [PROD_W-1:0]       r_prod;
    logic [ACC_W-1:0]        r_acc;
    logic [LIM_W-1:0]        r_lim;
    logic signed [DIFF_W-1:0] dev;
    logic [DIFF_W-1:0]       dev_abs;
    logic                    pass_done;
    logic                    kept;

    // Held-back result
    logic                    r_pend_v;
    logic [IDX_W-1:0]        r_pend_i;
    logic [HEIGHT_W-1:0]     r_pend_h;
    logic                    r_out_v;
    logic                    n_out_v;
    t_out_item               r_out;

    assign busy   = (r_state != ST_LOAD);
    assign accept = start && !busy;
    assign n_cnt  = r_cnt + CNT_W'(1);
    assign n_sum  = r_sum + SUM_W'(i_item.height);
    assign closes = i_item.last_point || (n_cnt == CNT_W'(MAX_POINTS));

    // Restoring division step: remainder stays below n, so one bit of headroom.
    assign div_trial = {r_rem, r_dq[SUM_W-1]};
    assign div_bit   = (div_trial >= {1'b0, r_n});

    // Issue one read per cycle until every point of the set is requested.
    assign issue     = ((r_state == ST_VAR) || (r_state == ST_EMIT)) && (r_ptr != r_n);
    assign pass_done = (r_ptr == r_n) && !r_v0 && !r_v1 && !r_v2 && !r_v3;

    assign dev     = $signed({rdata[HEIGHT_W-1], rdata}) - $signed({r_mean[HEIGHT_W-1], r_mean});
    assign dev_abs = dev[DIFF_W-1] ? DIFF_W'(-dev) : DIFF_W'(dev);
    assign kept    = ({{(LIM_W-PROD_W){1'b0}}, r_prod} <= r_lim);

    // Release the held keeper when a newer keeper arrives or the pass ends.
    assign n_out_v = (r_state == ST_EMIT) && r_pend_v && ((r_v3 && kept) || pass_done);

    tshof_ram #(
        .WIDTH (HEIGHT_W),
        .DEPTH (MAX_POINTS)
    ) u_height_ram (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_cnt[IDX_W-1:0]),
        .i_wdata (i_item.height),
        .i_re    (issue),
        .i_raddr (r_ptr[IDX_W-1:0]),
        .o_rdata (rdata)
    );

    // Control: state, counts, pipeline valids and the result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_LOAD;
            r_cnt    <= '0;
            r_sum    <= '0;
            r_dcnt   <= '0;
            r_ptr    <= '0;
            r_v0     <= 1'b0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_v0    <= issue;
            r_v1    <= r_v0;
            r_v2    <= r_v1;
            r_v3    <= r_v2 && (r_state == ST_EMIT);
            r_out_v <= n_out_v;
            if (issue) begin
                r_ptr <= r_ptr + CNT_W'(1);
            end
            case (r_state)
                ST_LOAD: begin
                    if (accept) begin
                        if (closes) begin
                            // Set closed: clear the running totals, start the divider.
                            r_cnt   <= '0;
                            r_sum   <= '0;
                            r_dcnt  <= DIV_STEPS;
                            r_state <= ST_DIV;
                        end else begin
                            r_cnt <= n_cnt;
                            r_sum <= n_sum;
                        end
                    end
                end
                ST_DIV: begin
                    if (r_dcnt == '0) begin
                        r_ptr   <= '0;
                        r_state <= ST_VAR;
                    end else begin
                        r_dcnt <= r_dcnt - 5'd1;
                    end
                end
                ST_VAR: begin
                    if (pass_done) begin
                        r_ptr   <= '0;
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (r_v3 && kept) begin
                        // Hold this keeper back; the previous one goes out.
                        r_pend_v <= 1'b1;
                    end else if (pass_done) begin
                        // Last keeper of the set goes out marked last.
                        r_pend_v <= 1'b0;
                        r_state  <= ST_LOAD;
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
        end
    end

    // Datapath: divider, deviation pipeline, sums and held-back result.
    always_ff @(posedge i_clk) begin
        if (accept && closes) begin
            r_n   <= n_cnt;
            r_neg <= n_sum[SUM_W-1];
            r_dq  <= n_sum[SUM_W-1] ? SUM_W'(-n_sum) : SUM_W'(n_sum);
            r_rem <= '0;
            r_acc <= '0;
        end
        if (r_state == ST_DIV) begin
            if (r_dcnt != '0) begin
                r_rem <= div_bit ? CNT_W'(div_trial - {1'b0, r_n}) : div_trial[CNT_W-1:0];
                r_dq  <= {r_dq[SUM_W-2:0], div_bit};
            end else begin
                // Truncate toward zero: negate the magnitude quotient.
                r_mean <= r_neg ? HEIGHT_W'(-r_dq[HEIGHT_W-1:0]) : r_dq[HEIGHT_W-1:0];
            end
        end
        if (r_state == ST_VAR) begin
            if (r_v2) begin
                r_acc <= r_acc + ACC_W'(r_sq);
            end
            if (pass_done) begin
                r_lim <= {r_acc, 2'b00};
            end
        end

        r_i0   <= r_ptr[IDX_W-1:0];
        r_i1   <= r_i0;
        r_h1   <= rdata;
        r_absd <= dev_abs[HEIGHT_W-1:0];
        r_i2   <= r_i1;
        r_h2   <= r_h1;
        r_sq   <= SQ_W'(r_absd) * SQ_W'(r_absd);
        r_i3   <= r_i2;
        r_h3   <= r_h2;
        r_prod <= PROD_W'(r_n) * PROD_W'(r_sq);

        if ((r_state == ST_EMIT) && r_v3 && kept) begin
            r_pend_i <= r_i3;
            r_pend_h <= r_h3;
        end
        r_out.point_index <= r_pend_i;
        r_out.kept_height <= r_pend_h;
        r_out.last_kept   <= !(r_v3 && kept);
    end

    assign o_result_valid = r_out_v;
    assign o_result       = r_out;

endmodule
`default_nettype wire

// ===== rtl/core/tshof_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module tshof_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire
